FILE: sv/mm4_pkg.sv
package mm4_pkg;

  localparam int unsigned DIM                = 4;
  localparam int unsigned ROW_W              = 2;
  localparam int unsigned FRAC_BITS          = 16;
  localparam int unsigned PORT_W             = 32;
  localparam int unsigned ELEM_WIDTH_DEFAULT = 32;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_MULTIPLY = 1'b1;

  // write request toward the right matrix store
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } coef_wr_t;

endpackage

FILE: sv/mm4_coef_store.sv
module mm4_coef_store
  import mm4_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  coef_wr_t                     wr_i,
  input  logic signed [ELEM_WIDTH-1:0] row_data_i [DIM],
  output logic signed [ELEM_WIDTH-1:0] coef_o     [DIM][DIM]
);

  logic signed [ELEM_WIDTH-1:0] coef_q [DIM][DIM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIM; k++) begin
        for (int j = 0; j < DIM; j++) begin
          coef_q[k][j] <= '0;
        end
      end
    end else if (wr_i.en) begin
      for (int j = 0; j < DIM; j++) begin
        coef_q[wr_i.row][j] <= row_data_i[j];
      end
    end
  end

  assign coef_o = coef_q;

endmodule

FILE: sv/mm4_product.sv
module mm4_product
  import mm4_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
  localparam int unsigned PROD_W    = 2 * ELEM_WIDTH - FRAC_BITS
) (
  input  logic signed [ELEM_WIDTH-1:0] a_i    [DIM],
  input  logic signed [ELEM_WIDTH-1:0] coef_i [DIM][DIM],
  output logic signed [PROD_W-1:0]     prod_o [DIM][DIM]
);

  // one multiplier per (k, j) pair; dropping the fraction bits of a
  // two's complement product rounds toward minus infinity
  for (genvar k = 0; k < DIM; k++) begin : g_row
    for (genvar j = 0; j < DIM; j++) begin : g_col
      logic signed [2*ELEM_WIDTH-1:0] full;
      assign full         = a_i[k] * coef_i[k][j];
      assign prod_o[k][j] = full[2*ELEM_WIDTH-1:FRAC_BITS];
    end
  end

endmodule

FILE: sv/mm4_row_sum.sv
module mm4_row_sum
  import mm4_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
  localparam int unsigned PROD_W    = 2 * ELEM_WIDTH - FRAC_BITS,
  localparam int unsigned SUM_W     = PROD_W + 2
) (
  input  logic signed [PROD_W-1:0]     prod_i [DIM],
  output logic signed [ELEM_WIDTH-1:0] sum_o,
  output logic                         clip_o
);

  localparam logic signed [SUM_W-1:0] SumMax =
    {{(SUM_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SumMin =
    {{(SUM_W-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}};

  logic signed [SUM_W-1:0] acc;

  always_comb begin
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      acc = acc + SUM_W'(prod_i[k]);
    end
  end

  always_comb begin
    if (acc > SumMax) begin
      sum_o  = SumMax[ELEM_WIDTH-1:0];
      clip_o = 1'b1;
    end else if (acc < SumMin) begin
      sum_o  = SumMin[ELEM_WIDTH-1:0];
      clip_o = 1'b1;
    end else begin
      sum_o  = acc[ELEM_WIDTH-1:0];
      clip_o = 1'b0;
    end
  end

endmodule

FILE: sv/matrix_multiply_4x4_rows.sv
// 4x4 fixed-point matrix multiply, streamed one row at a time.
// Input channel (in_valid_i / in_ready_o): operation_i selects a load of
// row row_index_i of the right matrix B, or a multiply of the row
// elem0_i..elem3_i of A by B. Elements are signed with 16 fraction bits;
// only the low ELEM_WIDTH bits of each input element are used.
// Output channel (out_valid_o / out_ready_i): one transaction per multiply,
// none per load. out0_o..out3_o are the product row, saturated to the
// ELEM_WIDTH range and sign-extended; saturated_o flags any clipping.
// A multiply passes through the input register, product register and result
// register before it is presented. Throughput: one transaction per cycle
// unless stalled; the sixteen products are formed in parallel, and a load
// takes effect for every multiply accepted after it.
// Reset clears B to zero and empties the pipeline.
// When the receiver stalls, the stages fill up one after another; in_ready_o
// drops once the result and product registers hold work and a multiply waits
// in the input register; a load waiting there still retires.
module matrix_multiply_4x4_rows
  import mm4_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [ROW_W-1:0]         row_index_i,
  input  logic signed [PORT_W-1:0] elem0_i,
  input  logic signed [PORT_W-1:0] elem1_i,
  input  logic signed [PORT_W-1:0] elem2_i,
  input  logic signed [PORT_W-1:0] elem3_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [PORT_W-1:0] out0_o,
  output logic signed [PORT_W-1:0] out1_o,
  output logic signed [PORT_W-1:0] out2_o,
  output logic signed [PORT_W-1:0] out3_o,
  output logic                     saturated_o
);

  localparam int unsigned PROD_W = 2 * ELEM_WIDTH - FRAC_BITS;

  // input register
  logic                         s0_valid_q;
  logic                         s0_op_q;
  logic [ROW_W-1:0]             s0_row_q;
  logic signed [ELEM_WIDTH-1:0] s0_elem_q [DIM];

  // product register
  logic                         s1_valid_q;
  logic signed [PROD_W-1:0]     s1_prod_q [DIM][DIM];

  // result register
  logic                         out_valid_q;
  logic signed [ELEM_WIDTH-1:0] out_q [DIM];
  logic                         sat_q;

  logic                         out_free;
  logic                         s1_ready;
  logic                         s0_go;
  logic                         s0_ready;
  coef_wr_t                     coef_wr;
  logic signed [ELEM_WIDTH-1:0] coef [DIM][DIM];
  logic signed [PROD_W-1:0]     prod [DIM][DIM];
  logic signed [PROD_W-1:0]     col_prod [DIM][DIM];
  logic signed [ELEM_WIDTH-1:0] col_sum [DIM];
  logic [DIM-1:0]               col_clip;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_ready = !s1_valid_q || out_free;
  // a load leaves no work behind, so it may retire while the next stage is full
  assign s0_go    = s0_valid_q && (s1_ready || (s0_op_q == OP_LOAD));
  assign s0_ready = !s0_valid_q || s0_go;

  assign in_ready_o = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_op_q      <= operation_i;
      s0_row_q     <= row_index_i;
      s0_elem_q[0] <= elem0_i[ELEM_WIDTH-1:0];
      s0_elem_q[1] <= elem1_i[ELEM_WIDTH-1:0];
      s0_elem_q[2] <= elem2_i[ELEM_WIDTH-1:0];
      s0_elem_q[3] <= elem3_i[ELEM_WIDTH-1:0];
    end
  end

  assign coef_wr.en  = s0_go && (s0_op_q == OP_LOAD);
  assign coef_wr.row = s0_row_q;

  mm4_coef_store #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_coef_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (coef_wr),
    .row_data_i (s0_elem_q),
    .coef_o     (coef)
  );

  mm4_product #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_product (
    .a_i    (s0_elem_q),
    .coef_i (coef),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s0_go && (s0_op_q == OP_MULTIPLY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_prod_q <= prod;
    end
  end

  // regroup products by output column
  for (genvar j = 0; j < DIM; j++) begin : g_col
    for (genvar k = 0; k < DIM; k++) begin : g_term
      assign col_prod[j][k] = s1_prod_q[k][j];
    end

    mm4_row_sum #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_row_sum (
      .prod_i (col_prod[j]),
      .sum_o  (col_sum[j]),
      .clip_o (col_clip[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= col_sum;
      sat_q <= |col_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out0_o      = PORT_W'(out_q[0]);
  assign out1_o      = PORT_W'(out_q[1]);
  assign out2_o      = PORT_W'(out_q[2]);
  assign out3_o      = PORT_W'(out_q[3]);
  assign saturated_o = sat_q;

  // a load never turns into a product row
  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_go && (s0_op_q == OP_LOAD) && s1_ready) |=> !s1_valid_q)
    else $error("load transaction produced a product row");

  // an empty result register never holds back the input
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled while result register empty");

  // a product row moves on to the result register when it is free
  a_product_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_q)
    else $error("product row lost on its way to the output");

  // every result comes from a product row
  a_result_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a product row");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench
  import mm4_pkg::*;
();

  localparam int unsigned ELEM_WIDTH = ELEM_WIDTH_DEFAULT;
  localparam int RANDOM_ROWS = 1150;
  // longest quiet stretch is the receiver hold-off plus a sender gap
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic                          op;
    logic [ROW_W-1:0]              row;
    logic [DIM-1:0][PORT_W-1:0]    elem;
  } row_item_t;

  typedef struct packed {
    logic [DIM-1:0][PORT_W-1:0]    col;
    logic                          sat;
  } product_row_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_SPARSE} ready_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              operation_i = OP_LOAD;
  logic [ROW_W-1:0]  row_index_i = '0;
  logic [PORT_W-1:0] elem0_i = '0;
  logic [PORT_W-1:0] elem1_i = '0;
  logic [PORT_W-1:0] elem2_i = '0;
  logic [PORT_W-1:0] elem3_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PORT_W-1:0] out0_o, out1_o, out2_o, out3_o;
  logic              saturated_o;

  row_item_t         pending_rows[$];
  product_row_t      expected_products[$];
  logic [ELEM_WIDTH-1:0] coef_store [DIM*DIM];
  row_item_t         offered;
  int                burst_left;
  int                gap_left;
  int                error_count;
  int                results_seen;
  int                idle_cycles;
  int                hold_left;
  bit                hold_done;
  int                mode_left;
  int                sparse_phase;
  ready_mode_e       ready_mode;

  matrix_multiply_4x4_rows #(.ELEM_WIDTH(ELEM_WIDTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .row_index_i (row_index_i),
    .elem0_i     (elem0_i),
    .elem1_i     (elem1_i),
    .elem2_i     (elem2_i),
    .elem3_i     (elem3_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out0_o      (out0_o),
    .out1_o      (out1_o),
    .out2_o      (out2_o),
    .out3_o      (out3_o),
    .saturated_o (saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // only the low ELEM_WIDTH bits count, read as signed
  function automatic longint as_fixed(input logic [PORT_W-1:0] raw);
    logic signed [ELEM_WIDTH-1:0] v;
    v = raw[ELEM_WIDTH-1:0];
    return longint'(v);
  endfunction

  function automatic product_row_t product_of(input row_item_t a);
    product_row_t r;
    longint acc;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ELEM_WIDTH - 1)) - 1;
    lo = -hi - 1;
    r.sat = 1'b0;
    for (int j = 0; j < DIM; j++) begin
      acc = 0;
      // arithmetic shift floors each product
      for (int k = 0; k < DIM; k++)
        acc += (as_fixed(a.elem[k]) * as_fixed(PORT_W'(coef_store[k*DIM+j]))) >>> FRAC_BITS;
      if (acc > hi) begin
        acc = hi;
        r.sat = 1'b1;
      end else if (acc < lo) begin
        acc = lo;
        r.sat = 1'b1;
      end
      r.col[j] = PORT_W'(acc);
    end
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [ROW_W-1:0] row,
                         input logic [PORT_W-1:0] e0, input logic [PORT_W-1:0] e1,
                         input logic [PORT_W-1:0] e2, input logic [PORT_W-1:0] e3);
    row_item_t it;
    it.op = op;
    it.row = row;
    it.elem[0] = e0;
    it.elem[1] = e1;
    it.elem[2] = e2;
    it.elem[3] = e3;
    pending_rows.push_back(it);
  endtask

  function automatic logic [PORT_W-1:0] rand_elem();
    int v;
    case ($urandom_range(0, 6))
      0, 1: return $urandom();
      2, 3: begin
        v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        return PORT_W'(v);
      end
      4: begin
        v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        return PORT_W'(v);
      end
      5: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          4: return 32'h0001_0000;
          default: return 32'hffff_0000;
        endcase
      end
      default: begin
        v = 32'h0001_0000 + int'($urandom_range(0, 64)) - 32;
        return ($urandom_range(0, 1) != 0) ? PORT_W'(v) : PORT_W'(-v);
      end
    endcase
  endfunction

  task automatic add_random_row(input logic op, input logic [ROW_W-1:0] row);
    add_row(op, row, rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endtask

  // sender: bursts of transactions separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= OP_LOAD;
      row_index_i <= '0;
      elem0_i <= '0;
      elem1_i <= '0;
      elem2_i <= '0;
      elem3_i <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
      for (int i = 0; i < DIM*DIM; i++)
        coef_store[i] = '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (offered.op == OP_LOAD) begin
          for (int j = 0; j < DIM; j++)
            coef_store[int'(offered.row)*DIM + j] = offered.elem[j][ELEM_WIDTH-1:0];
        end else begin
          expected_products.push_back(product_of(offered));
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          offered = pending_rows.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= offered.op;
          row_index_i <= offered.row;
          elem0_i <= offered.elem[0];
          elem1_i <= offered.elem[1];
          elem2_i <= offered.elem[2];
          elem3_i <= offered.elem[3];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches at random intervals, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      mode_left = 0;
      sparse_phase = 0;
      ready_mode = READY_ALWAYS;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      sparse_phase++;
      case (ready_mode)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_COIN:   out_ready_i <= ($urandom_range(0, 1) != 0);
        READY_MOSTLY: out_ready_i <= ($urandom_range(0, 9) != 0);
        default:      out_ready_i <= (sparse_phase % 4 == 0);
      endcase
    end
  end

  task automatic flag_mismatch(input string what, input logic [PORT_W-1:0] want,
                               input logic [PORT_W-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin
    product_row_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_products.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result transaction with no multiply pending", $time);
      end else begin
        want = expected_products.pop_front();
        if (out0_o !== want.col[0]) flag_mismatch("out0", want.col[0], out0_o);
        if (out1_o !== want.col[1]) flag_mismatch("out1", want.col[1], out1_o);
        if (out2_o !== want.col[2]) flag_mismatch("out2", want.col[2], out2_o);
        if (out3_o !== want.col[3]) flag_mismatch("out3", want.col[3], out3_o);
        if (saturated_o !== want.sat)
          flag_mismatch("saturated", PORT_W'(want.sat), PORT_W'(saturated_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int added;
    int n;
    int first;
    error_count = 0;
    results_seen = 0;
    idle_cycles = 0;

    // multiply straight after reset sees an all-zero B
    add_row(OP_MULTIPLY, 2'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    // identity
    add_row(OP_LOAD, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    add_row(OP_LOAD, 2'd1, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    add_row(OP_LOAD, 2'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    add_row(OP_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    add_row(OP_MULTIPLY, 2'd3, 32'h0001_8000, 32'hfffe_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_row(OP_MULTIPLY, 2'd1, 32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h0);
    // tiny coefficients exercise rounding toward minus infinity
    add_row(OP_LOAD, 2'd0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0003, 32'h8000_0000);
    add_row(OP_MULTIPLY, 2'd0, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
    add_row(OP_MULTIPLY, 2'd2, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    // full-scale B drives the sums past both rails
    for (int r = 0; r < DIM; r++)
      add_row(OP_LOAD, ROW_W'(r), 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(OP_MULTIPLY, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(OP_MULTIPLY, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(OP_MULTIPLY, 2'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_row(OP_LOAD, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(OP_MULTIPLY, 2'd0, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
    add_row(OP_MULTIPLY, 2'd0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0);
    add_row(OP_LOAD, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0);
    add_row(OP_MULTIPLY, 2'd1, 32'hffff_0000, 32'h0000_8000, 32'h7fff_ffff, 32'h0001_0000);

    added = 0;
    while (added < RANDOM_ROWS) begin
      if ($urandom_range(0, 3) != 0) begin
        // reload some rows of B, then stream A rows through it
        n = $urandom_range(1, 4);
        first = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
          add_random_row(OP_LOAD, ROW_W'((first + i) % DIM));
        added += n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          add_random_row(OP_MULTIPLY, ROW_W'($urandom_range(0, 3)));
        added += n;
      end else begin
        add_random_row(($urandom_range(0, 1) != 0) ? OP_MULTIPLY : OP_LOAD,
                       ROW_W'($urandom_range(0, 3)));
        added++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_rows.size() != 0 || in_valid_i || expected_products.size() != 0);
    repeat (8) @(negedge clk_i);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mm4_pkg.sv
sv/mm4_coef_store.sv
sv/mm4_product.sv
sv/mm4_row_sum.sv
sv/matrix_multiply_4x4_rows.sv
verif/testbench.sv
